FILE: hw/rtl/accumulator_integer_alu_unit_defines.svh
// ----------------------------------------------------------------------------
// Accumulator integer ALU assertion macros
// Shorthands for the concurrent checks of the accumulator integer ALU.
// ----------------------------------------------------------------------------
`ifndef ACCUMULATOR_INTEGER_ALU_UNIT_DEFINES_SVH
`define ACCUMULATOR_INTEGER_ALU_UNIT_DEFINES_SVH

// Same-cycle implication: cons is checked from the cycle in which ante holds.
`define AIA_ASSERT_IMP(lbl, clk, rst, ante, cons, msg) \
   lbl: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) \
      else $error(msg);

// Next-cycle implication: cons is checked in the cycle after ante.
`define AIA_ASSERT_NXT(lbl, clk, rst, ante, cons, msg) \
   lbl: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) \
      else $error(msg);

`endif

FILE: hw/rtl/aia_pkg.sv
// ----------------------------------------------------------------------------
// Accumulator integer ALU package
// Payload types, operation codes, microcode format and the control store.
// ----------------------------------------------------------------------------
`default_nettype none

package aia_pkg;

   localparam int DATA_W = 32;
   localparam int OP_W   = 3;
   localparam int UPC_W  = 5;
   localparam int CNT_W  = 5;

   localparam logic [OP_W-1:0] OP_ADD = 3'd0;
   localparam logic [OP_W-1:0] OP_SUB = 3'd1;
   localparam logic [OP_W-1:0] OP_MUL = 3'd2;
   localparam logic [OP_W-1:0] OP_DIV = 3'd3;
   localparam logic [OP_W-1:0] OP_POW = 3'd4;
   localparam logic [OP_W-1:0] OP_MOD = 3'd5;

   typedef struct packed {
      logic [OP_W-1:0]          op;
      logic                     use_accumulator;
      logic signed [DATA_W-1:0] operand_a;
      logic signed [DATA_W-1:0] operand_b;
   } req_type;

   typedef struct packed {
      logic signed [DATA_W-1:0] result_value;
      logic                     zero_divisor;
   } rsp_type;

   // Datapath operations, one per microinstruction
   typedef enum logic [3:0] {
      UOP_NONE,
      UOP_ADD,
      UOP_SUB,
      UOP_MUL,
      UOP_DIV_INIT,
      UOP_DIV_STEP,
      UOP_QUO_RES,
      UOP_REM_RES,
      UOP_POW_INIT,
      UOP_POW_STEP,
      UOP_POW_RES,
      UOP_PASS_A,
      UOP_ZERO_RES,
      UOP_ONE_RES,
      UOP_HOLD_ACC
   } uop_type;

   // Jump conditions, taken when true
   typedef enum logic [2:0] {
      COND_NEVER,
      COND_Y_ZERO,
      COND_X_ZERO,
      COND_CNT_MORE,
      COND_EXP_NPOS,
      COND_EXP_MORE
   } cond_type;

   typedef struct packed {
      uop_type          uop;
      cond_type         cond;
      logic [UPC_W-1:0] target;
      logic             last;
   } uword_type;

   // Control from sequencer to datapath
   typedef struct packed {
      uop_type uop;
      logic    exec;
      logic    last;
   } ctl_type;

   // Branch status from datapath to sequencer
   typedef struct packed {
      logic y_zero;
      logic x_zero;
      logic cnt_more;
      logic exp_npos;
      logic exp_more;
   } status_type;

   // Program addresses
   localparam logic [UPC_W-1:0] A_ADD      = 5'd0;
   localparam logic [UPC_W-1:0] A_SUB      = 5'd1;
   localparam logic [UPC_W-1:0] A_MUL      = 5'd2;
   localparam logic [UPC_W-1:0] A_DIV      = 5'd3;
   localparam logic [UPC_W-1:0] A_DIV_LOOP = 5'd4;
   localparam logic [UPC_W-1:0] A_DIV_RES  = 5'd5;
   localparam logic [UPC_W-1:0] A_MOD      = 5'd6;
   localparam logic [UPC_W-1:0] A_MOD_LOOP = 5'd7;
   localparam logic [UPC_W-1:0] A_MOD_RES  = 5'd8;
   localparam logic [UPC_W-1:0] A_POW      = 5'd9;
   localparam logic [UPC_W-1:0] A_POW_EXP  = 5'd10;
   localparam logic [UPC_W-1:0] A_POW_LOOP = 5'd11;
   localparam logic [UPC_W-1:0] A_POW_RES  = 5'd12;
   localparam logic [UPC_W-1:0] A_ZDIV     = 5'd13;
   localparam logic [UPC_W-1:0] A_ZERO     = 5'd14;
   localparam logic [UPC_W-1:0] A_ONE      = 5'd15;
   localparam logic [UPC_W-1:0] A_HOLD     = 5'd16;

   localparam logic [UPC_W-1:0] A_NONE = '0;

   function automatic uword_type aia_ucode(input logic [UPC_W-1:0] addr);
      uword_type w;
      w = '{UOP_HOLD_ACC, COND_NEVER, A_NONE, 1'b1};
      unique case (addr)
         A_ADD:      w = '{UOP_ADD,      COND_NEVER,    A_NONE,     1'b1};
         A_SUB:      w = '{UOP_SUB,      COND_NEVER,    A_NONE,     1'b1};
         A_MUL:      w = '{UOP_MUL,      COND_NEVER,    A_NONE,     1'b1};
         A_DIV:      w = '{UOP_DIV_INIT, COND_Y_ZERO,   A_ZDIV,     1'b0};
         A_DIV_LOOP: w = '{UOP_DIV_STEP, COND_CNT_MORE, A_DIV_LOOP, 1'b0};
         A_DIV_RES:  w = '{UOP_QUO_RES,  COND_NEVER,    A_NONE,     1'b1};
         A_MOD:      w = '{UOP_DIV_INIT, COND_Y_ZERO,   A_ZDIV,     1'b0};
         A_MOD_LOOP: w = '{UOP_DIV_STEP, COND_CNT_MORE, A_MOD_LOOP, 1'b0};
         A_MOD_RES:  w = '{UOP_REM_RES,  COND_NEVER,    A_NONE,     1'b1};
         A_POW:      w = '{UOP_POW_INIT, COND_X_ZERO,   A_ZERO,     1'b0};
         A_POW_EXP:  w = '{UOP_NONE,     COND_EXP_NPOS, A_ONE,      1'b0};
         A_POW_LOOP: w = '{UOP_POW_STEP, COND_EXP_MORE, A_POW_LOOP, 1'b0};
         A_POW_RES:  w = '{UOP_POW_RES,  COND_NEVER,    A_NONE,     1'b1};
         A_ZDIV:     w = '{UOP_PASS_A,   COND_NEVER,    A_NONE,     1'b1};
         A_ZERO:     w = '{UOP_ZERO_RES, COND_NEVER,    A_NONE,     1'b1};
         A_ONE:      w = '{UOP_ONE_RES,  COND_NEVER,    A_NONE,     1'b1};
         A_HOLD:     w = '{UOP_HOLD_ACC, COND_NEVER,    A_NONE,     1'b1};
         default:    w = '{UOP_HOLD_ACC, COND_NEVER,    A_NONE,     1'b1};
      endcase
      return w;
   endfunction

   // Dispatch: program entry for each operation code
   function automatic logic [UPC_W-1:0] aia_entry(input logic [OP_W-1:0] op);
      logic [UPC_W-1:0] e;
      e = A_HOLD;
      unique case (op)
         OP_ADD:  e = A_ADD;
         OP_SUB:  e = A_SUB;
         OP_MUL:  e = A_MUL;
         OP_DIV:  e = A_DIV;
         OP_POW:  e = A_POW;
         OP_MOD:  e = A_MOD;
         default: e = A_HOLD;
      endcase
      return e;
   endfunction

endpackage

`default_nettype wire

FILE: hw/rtl/accumulator_integer_alu_unit.sv
// ----------------------------------------------------------------------------
// Accumulator integer ALU
// 32-bit signed calculator with accumulator, run by a microcoded sequencer.
// ----------------------------------------------------------------------------
//
//   Channel   Dir   Handshake              Payload
//   req       in    req_valid/req_ready    req_data (req_type)
//   rsp       out   rsp_valid/rsp_ready    rsp_data (rsp_type)
//
// From accept to the result register: add, subtract, multiply, no-op end in
// their entry step; divide and modulo end early on a zero divisor, else take
// one quotient bit per divide-loop step; power ends early on a zero base or a
// non-positive exponent, else squares and multiplies once per exponent bit.
// One item in flight; req_ready returns the cycle after the final step. A
// final step holds while rsp_data is still full, so a finished result may
// wait there while the next item runs. Synchronous reset clears the
// accumulator and all handshake state.
// ----------------------------------------------------------------------------
`default_nettype none

module accumulator_integer_alu_unit
   import aia_pkg::*;
(
   input  logic    clock,
   input  logic    reset,
   input  logic    req_valid,
   output logic    req_ready,
   input  req_type req_data,
   output logic    rsp_valid,
   input  logic    rsp_ready,
   output rsp_type rsp_data
);

   logic       busy;
   logic       start;
   logic       out_busy;
   ctl_type    ctl;
   status_type status;
   rsp_type    res;

   logic       rsp_valid_ff, rsp_valid_in;
   rsp_type    rsp_ff;

   // take a new item only when the sequencer is idle
   assign req_ready = !busy;
   assign start     = req_valid && req_ready;

   // result register stays occupied unless this cycle drains it
   assign out_busy  = rsp_valid_ff && !rsp_ready;

   aia_useq u_useq (
      .clock    (clock),
      .reset    (reset),
      .start    (start),
      .op       (req_data.op),
      .status   (status),
      .out_busy (out_busy),
      .ctl      (ctl),
      .busy     (busy)
   );

   aia_dpath u_dpath (
      .clock  (clock),
      .reset  (reset),
      .load   (start),
      .req    (req_data),
      .ctl    (ctl),
      .status (status),
      .res    (res)
   );

   // advance the result register on a final step, drop it on transfer
   always_comb begin
      rsp_valid_in = rsp_valid_ff;
      if (ctl.exec && ctl.last) begin
         rsp_valid_in = 1'b1;
      end else if (rsp_ready) begin
         rsp_valid_in = 1'b0;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         rsp_valid_ff <= 1'b0;
      end else begin
         rsp_valid_ff <= rsp_valid_in;
      end
   end

   always_ff @(posedge clock) begin
      if (ctl.exec && ctl.last) begin
         rsp_ff <= res;
      end
   end

   assign rsp_valid = rsp_valid_ff;
   assign rsp_data  = rsp_ff;

endmodule

`default_nettype wire

FILE: hw/rtl/aia_useq.sv
// ----------------------------------------------------------------------------
// Accumulator integer ALU sequencer
// Step counter over the control store with dispatch and conditional jumps.
// ----------------------------------------------------------------------------
`default_nettype none

module aia_useq
   import aia_pkg::*;
(
   input  logic             clock,
   input  logic             reset,
   input  logic             start,
   input  logic [OP_W-1:0]  op,
   input  status_type       status,
   input  logic             out_busy,
   output ctl_type          ctl,
   output logic             busy
);

   logic             busy_ff, busy_in;
   logic [UPC_W-1:0] upc_ff, upc_in;
   uword_type        word;
   logic             taken;
   logic             exec;

   always_comb begin
      word = aia_ucode(upc_ff);
      // a final step waits while the result register is still full
      exec = busy_ff && !(word.last && out_busy);

      case (word.cond)
         COND_Y_ZERO:   taken = status.y_zero;
         COND_X_ZERO:   taken = status.x_zero;
         COND_CNT_MORE: taken = status.cnt_more;
         COND_EXP_NPOS: taken = status.exp_npos;
         COND_EXP_MORE: taken = status.exp_more;
         default:       taken = 1'b0;
      endcase

      busy_in = busy_ff;
      upc_in  = upc_ff;
      if (start) begin
         busy_in = 1'b1;
         upc_in  = aia_entry(op);
      end else if (exec) begin
         if (word.last) begin
            busy_in = 1'b0;
         end else if (taken) begin
            upc_in = word.target;
         end else begin
            upc_in = upc_ff + 1'b1;
         end
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         busy_ff <= 1'b0;
         upc_ff  <= '0;
      end else begin
         busy_ff <= busy_in;
         upc_ff  <= upc_in;
      end
   end

   assign ctl.uop  = word.uop;
   assign ctl.exec = exec;
   assign ctl.last = word.last;
   assign busy     = busy_ff;

endmodule

`default_nettype wire

FILE: hw/rtl/aia_dpath.sv
// ----------------------------------------------------------------------------
// Accumulator integer ALU datapath
// Operand registers, shared multiplier, divide step and accumulator.
// ----------------------------------------------------------------------------
`default_nettype none

module aia_dpath
   import aia_pkg::*;
(
   input  logic       clock,
   input  logic       reset,
   input  logic       load,
   input  req_type    req,
   input  ctl_type    ctl,
   output status_type status,
   output rsp_type    res
);

   logic [DATA_W-1:0] acc_ff, acc_in;
   logic [DATA_W-1:0] x_ff, y_ff;
   logic [DATA_W-1:0] hi_ff, hi_in;     // remainder or power product
   logic [DATA_W-1:0] lo_ff, lo_in;     // quotient or power base
   logic [DATA_W-1:0] dv_ff, dv_in;     // divisor magnitude or exponent
   logic [CNT_W-1:0]  cnt_ff, cnt_in;
   logic              sx_ff, sx_in, sy_ff, sy_in;

   logic [DATA_W-1:0] mag_x, mag_y;
   logic [DATA_W-1:0] mul_a, mul_b, prod, sq;
   logic [DATA_W:0]   shl, diff;
   logic [DATA_W-1:0] value;

   always_comb begin
      mag_x = x_ff[DATA_W-1] ? (~x_ff + 1'b1) : x_ff;
      mag_y = y_ff[DATA_W-1] ? (~y_ff + 1'b1) : y_ff;

      // one multiplier serves plain multiply and the product update of power
      mul_a = (ctl.uop == UOP_MUL) ? x_ff : hi_ff;
      mul_b = (ctl.uop == UOP_MUL) ? y_ff : lo_ff;
      prod  = mul_a * mul_b;
      sq    = lo_ff * lo_ff;

      shl  = {hi_ff, lo_ff[DATA_W-1]};
      diff = shl - {1'b0, dv_ff};

      case (ctl.uop)
         UOP_ADD:      value = x_ff + y_ff;
         UOP_SUB:      value = x_ff - y_ff;
         UOP_MUL:      value = prod;
         UOP_QUO_RES:  value = (sx_ff ^ sy_ff) ? (~lo_ff + 1'b1) : lo_ff;
         UOP_REM_RES:  value = sx_ff ? (~hi_ff + 1'b1) : hi_ff;
         UOP_POW_RES:  value = hi_ff;
         UOP_PASS_A:   value = x_ff;
         UOP_ZERO_RES: value = '0;
         UOP_ONE_RES:  value = DATA_W'(1);
         default:      value = acc_ff;
      endcase

      res.result_value = value;
      res.zero_divisor = (ctl.uop == UOP_PASS_A);

      status.y_zero   = (y_ff == '0);
      status.x_zero   = (x_ff == '0);
      status.cnt_more = (cnt_ff != '0);
      status.exp_npos = (dv_ff == '0) || dv_ff[DATA_W-1];
      status.exp_more = (dv_ff[DATA_W-1:1] != '0);

      hi_in  = hi_ff;
      lo_in  = lo_ff;
      dv_in  = dv_ff;
      cnt_in = cnt_ff;
      sx_in  = sx_ff;
      sy_in  = sy_ff;
      acc_in = acc_ff;
      if (ctl.exec) begin
         case (ctl.uop)
            UOP_DIV_INIT: begin
               hi_in  = '0;
               lo_in  = mag_x;
               dv_in  = mag_y;
               cnt_in = '1;
               sx_in  = x_ff[DATA_W-1];
               sy_in  = y_ff[DATA_W-1];
            end
            UOP_DIV_STEP: begin
               if (!diff[DATA_W]) begin
                  hi_in = diff[DATA_W-1:0];
               end else begin
                  hi_in = shl[DATA_W-1:0];
               end
               lo_in  = {lo_ff[DATA_W-2:0], ~diff[DATA_W]};
               cnt_in = cnt_ff - 1'b1;
            end
            UOP_POW_INIT: begin
               hi_in = DATA_W'(1);
               lo_in = x_ff;
               dv_in = y_ff;
            end
            UOP_POW_STEP: begin
               if (dv_ff[0]) begin
                  hi_in = prod;
               end
               lo_in = sq;
               dv_in = {1'b0, dv_ff[DATA_W-1:1]};
            end
            default: ;
         endcase
         if (ctl.last) begin
            acc_in = value;
         end
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         acc_ff <= '0;
      end else begin
         acc_ff <= acc_in;
      end
   end

   always_ff @(posedge clock) begin
      if (load) begin
         x_ff <= req.use_accumulator ? acc_ff : req.operand_a;
         y_ff <= req.operand_b;
      end
      hi_ff  <= hi_in;
      lo_ff  <= lo_in;
      dv_ff  <= dv_in;
      cnt_ff <= cnt_in;
      sx_ff  <= sx_in;
      sy_ff  <= sy_in;
   end

endmodule

`default_nettype wire

FILE: hw/rtl/aia_checker.sv
// ----------------------------------------------------------------------------
// Accumulator integer ALU checker
// Port-level assertions, bound to the top level.
// ----------------------------------------------------------------------------
`default_nettype none

`include "accumulator_integer_alu_unit_defines.svh"

module aia_checker
   import aia_pkg::*;
(
   input wire logic    clock,
   input wire logic    reset,
   input wire logic    req_valid,
   input wire logic    req_ready,
   input wire req_type req_data,
   input wire logic    rsp_valid,
   input wire logic    rsp_ready,
   input wire rsp_type rsp_data
);

   `AIA_ASSERT_NXT(a_reset_empty, clock, 1'b0, reset, !rsp_valid, "result after reset")

   `AIA_ASSERT_NXT(a_one_item, clock, reset, req_valid && req_ready, !req_ready, "second item taken while busy")

   `AIA_ASSERT_NXT(a_rsp_hold, clock, reset, rsp_valid && !rsp_ready, rsp_valid && $stable(rsp_data), "stalled result changed")

   `AIA_ASSERT_IMP(a_add_result, clock, reset, req_valid && req_ready && req_data.op == OP_ADD && !req_data.use_accumulator && !rsp_valid, ##2 (rsp_valid && !rsp_data.zero_divisor && rsp_data.result_value == $past(req_data.operand_a + req_data.operand_b, 2)), "wrong add result")

   `AIA_ASSERT_IMP(a_zero_div, clock, reset, req_valid && req_ready && req_data.op == OP_DIV && !req_data.use_accumulator && req_data.operand_b == 0 && !rsp_valid, ##3 (rsp_valid && rsp_data.zero_divisor && rsp_data.result_value == $past(req_data.operand_a, 3)), "wrong zero divisor result")

endmodule

bind accumulator_integer_alu_unit aia_checker u_aia_checker (.*);

`default_nettype wire
